/* hw/rtl/a2r_pkg.sv */
// Shared constants, types and Q30 arithmetic helpers for the angle-to-rotation-matrix block.
// Depends on nothing; every other file of the block imports it.
package a2r_pkg;

  localparam int QB              = 30;
  localparam int ANGLE_FRAC_BITS = 7;
  localparam int OUT_FRAC_BITS   = 14;

  localparam int ANG_W  = 17;
  localparam int ELEM_W = 16;
  localparam int Q_W    = 33;
  localparam int ACC_W  = Q_W + 2;
  localparam int X_W    = 30;
  localparam int X2_W   = 30;
  localparam int T_W    = 31;
  localparam int REM_W  = 14;
  localparam int HREM_W = 13;
  localparam int RED_W  = 16;
  localparam int SER_STEPS = 6;

  localparam int FULL_TURN    = 360 << ANGLE_FRAC_BITS;
  localparam int QUARTER_TURN = 90 << ANGLE_FRAC_BITS;
  localparam int EIGHTH_TURN  = 45 << ANGLE_FRAC_BITS;
  localparam int HALF_TURN    = 180 << ANGLE_FRAC_BITS;

  // pi in Q30, truncated; split so that rem * PI / HALF_TURN needs no divider
  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint RAD_Q  = PI_Q30 / HALF_TURN;
  localparam longint RAD_R  = PI_Q30 % HALF_TURN;
  // HALF_TURN = 45 << RAD_SH; divide by 45 through a reciprocal
  localparam int     RAD_SH    = ANGLE_FRAC_BITS + 2;
  localparam longint DIV45_M   = 372828;
  localparam int     DIV45_SH  = 24;

  localparam int     OUT_SH   = QB - OUT_FRAC_BITS;
  localparam longint OUT_HALF = (OUT_SH > 0) ? (longint'(1) << (OUT_SH - 1)) : 0;
  localparam longint OUT_ONE  = longint'(1) << OUT_FRAC_BITS;

  typedef logic signed [Q_W-1:0]   q_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic [ELEM_W-1:0]       elem_t;

  localparam q_t Q_ONE = q_t'(longint'(1) << QB);

  typedef struct packed {
    logic [T_W-1:0]  ts;
    logic [T_W-1:0]  tc;
    q_t              sa;
    q_t              ca;
    logic [X2_W-1:0] x2;
    logic [1:0]      quad;
    logic            swap;
  } ser_t;

  typedef struct packed {
    q_t s;
    q_t c;
  } sc_t;

  // Taylor divisors of step k: sine (2k)(2k+1) for five steps, cosine (2k-1)(2k)
  function automatic int sine_div(input int k);
    int d;
    case (k)
      1: d = 6;
      2: d = 20;
      3: d = 42;
      4: d = 72;
      5: d = 110;
      default: d = 0;
    endcase
    return d;
  endfunction

  function automatic int cos_div(input int k);
    return (2 * k - 1) * (2 * k);
  endfunction

  function automatic logic [Q_W-2:0] qmag(input q_t v);
    q_t n;
    n = -v;
    return v[Q_W-1] ? n[Q_W-2:0] : v[Q_W-2:0];
  endfunction

  // Q30 product rounded to nearest, half away from zero
  function automatic q_t qmul(input q_t a, input q_t b);
    logic        neg;
    logic [63:0] p;
    logic [63:0] m;
    neg = a[Q_W-1] ^ b[Q_W-1];
    p   = 64'(qmag(a)) * 64'(qmag(b));
    m   = (p + (64'd1 << (QB - 1))) >> QB;
    return neg ? -q_t'(m) : q_t'(m);
  endfunction

  // Q30 to output format, rounded half away from zero, saturated at one
  function automatic elem_t to_out(input acc_t v);
    logic [ACC_W-1:0] m;
    logic [ACC_W-1:0] r;
    m = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    m = (m + ACC_W'(OUT_HALF)) >> OUT_SH;
    if (m > ACC_W'(OUT_ONE)) m = ACC_W'(OUT_ONE);
    r = v[ACC_W-1] ? -m : m;
    return r[ELEM_W-1:0];
  endfunction

endpackage

/* hw/rtl/a2r_taylor_step.sv */
// One term of the sine and cosine Taylor series: t = round(t * x^2) / div, then accumulate.
// Three register stages. Depends on a2r_pkg.
module a2r_taylor_step #(
  parameter int SDIV = 6,
  parameter int CDIV = 2,
  parameter bit SUB  = 1'b1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  a2r_pkg::ser_t in_ser,
  output logic          out_valid,
  output a2r_pkg::ser_t out_ser
);
  import a2r_pkg::*;

  localparam int          SDIV_NZ = (SDIV == 0) ? 1 : SDIV;
  localparam logic [31:0] SM      = 32'((longint'(1) << 32) / SDIV_NZ);
  localparam logic [31:0] CM      = 32'((longint'(1) << 32) / CDIV);
  localparam int PW = T_W + X2_W;

  // stage a: products
  logic          va;
  ser_t          sera;
  logic [PW-1:0] psa, pca;
  // stage b: reciprocal estimates
  logic          vb;
  ser_t          serb;
  logic [31:0]   nsb, ncb, qsb, qcb;
  logic [31:0]   ns_next, nc_next;
  logic [63:0]   prs, prc;
  // stage c: corrected quotient and sum
  logic [31:0]   rs, rc, qs, qc;
  ser_t          ser_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sera <= in_ser;
      psa  <= PW'(in_ser.ts) * PW'(in_ser.x2);
      pca  <= PW'(in_ser.tc) * PW'(in_ser.x2);
      serb <= sera;
      nsb  <= ns_next;
      ncb  <= nc_next;
      qsb  <= prs[63:32];
      qcb  <= prc[63:32];
      out_ser <= ser_next;
    end
  end

  always_comb begin
    ns_next = 32'((psa + (PW'(1) << (QB - 1))) >> QB) + 32'(SDIV / 2);
    nc_next = 32'((pca + (PW'(1) << (QB - 1))) >> QB) + 32'(CDIV / 2);
    prs = 64'(ns_next) * 64'(SM);
    prc = 64'(nc_next) * 64'(CM);
  end

  always_comb begin
    rs = nsb - qsb * 32'(SDIV);
    rc = ncb - qcb * 32'(CDIV);
    qs = (rs >= 32'(SDIV_NZ)) ? qsb + 32'd1 : qsb;
    qc = (rc >= 32'(CDIV)) ? qcb + 32'd1 : qcb;
    ser_next = serb;
    if (SDIV != 0) begin
      ser_next.ts = T_W'(qs);
      ser_next.sa = SUB ? serb.sa - q_t'(qs) : serb.sa + q_t'(qs);
    end
    ser_next.tc = T_W'(qc);
    ser_next.ca = SUB ? serb.ca - q_t'(qc) : serb.ca + q_t'(qc);
  end

endmodule

/* hw/rtl/a2r_sincos.sv */
// Sine and cosine of one angle in Q30: reduction, radians, x^2, six Taylor steps, quadrant fold.
// Twenty-three register stages. Depends on a2r_pkg and a2r_taylor_step.
module a2r_sincos (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [a2r_pkg::ANG_W-1:0]  ang,
  output logic                              out_valid,
  output a2r_pkg::sc_t                      out_sc
);
  import a2r_pkg::*;

  // stage 1: wrap to one turn, split into quadrant and octant remainder
  logic signed [18:0]  a_ext, v;
  logic [17:0]         vu;
  logic [RED_W-1:0]    r;
  logic [1:0]          quad_next;
  logic [REM_W-1:0]    rem;
  logic                swap_next;
  logic                v1;
  logic [HREM_W-1:0]   hrem1;
  logic [1:0]          quad1;
  logic                swap1;

  always_comb begin
    a_ext = 19'(ang);
    v     = a_ext + 19'(2 * FULL_TURN);
    vu    = v[17:0];
    priority if (vu >= 18'(3 * FULL_TURN)) r = RED_W'(vu - 18'(3 * FULL_TURN));
    else if (vu >= 18'(2 * FULL_TURN))     r = RED_W'(vu - 18'(2 * FULL_TURN));
    else if (vu >= 18'(FULL_TURN))         r = RED_W'(vu - 18'(FULL_TURN));
    else                                   r = RED_W'(vu);
    priority if (r >= RED_W'(3 * QUARTER_TURN)) begin
      quad_next = 2'd3;
      rem = REM_W'(r - RED_W'(3 * QUARTER_TURN));
    end else if (r >= RED_W'(2 * QUARTER_TURN)) begin
      quad_next = 2'd2;
      rem = REM_W'(r - RED_W'(2 * QUARTER_TURN));
    end else if (r >= RED_W'(QUARTER_TURN)) begin
      quad_next = 2'd1;
      rem = REM_W'(r - RED_W'(QUARTER_TURN));
    end else begin
      quad_next = 2'd0;
      rem = REM_W'(r);
    end
    swap_next = rem > REM_W'(EIGHTH_TURN);
  end

  // stage 2: whole and fractional part of rem * pi / 180 deg
  logic              v2;
  logic [X_W-1:0]    hi2;
  logic [17:0]       lon2;
  logic [1:0]        quad2;
  logic              swap2;
  // stage 3: radians
  logic              v3;
  logic [X_W-1:0]    x3;
  logic [1:0]        quad3;
  logic              swap3;
  // stage 4: x^2 and series seed
  logic              v4;
  ser_t              ser4;
  logic [2*X_W-1:0]  xx;

  always_comb begin
    xx = (2*X_W)'(x3) * (2*X_W)'(x3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hrem1 <= swap_next ? HREM_W'(REM_W'(QUARTER_TURN) - rem) : HREM_W'(rem);
      quad1 <= quad_next;
      swap1 <= swap_next;
      hi2   <= X_W'(32'(hrem1) * 32'(RAD_Q));
      lon2  <= 18'((32'(hrem1) * 32'(RAD_R) + 32'(HALF_TURN / 2)) >> RAD_SH);
      quad2 <= quad1;
      swap2 <= swap1;
      x3    <= hi2 + X_W'((40'(lon2) * 40'(DIV45_M)) >> DIV45_SH);
      quad3 <= quad2;
      swap3 <= swap2;
      ser4.x2   <= X2_W'((xx + ((2*X_W)'(1) << (QB - 1))) >> QB);
      ser4.ts   <= T_W'(x3);
      ser4.tc   <= T_W'(Q_ONE);
      ser4.sa   <= q_t'(x3);
      ser4.ca   <= Q_ONE;
      ser4.quad <= quad3;
      ser4.swap <= swap3;
    end
  end

  // Taylor steps
  logic sv [SER_STEPS+1];
  ser_t ss [SER_STEPS+1];

  assign sv[0] = v4;
  assign ss[0] = ser4;

  for (genvar k = 1; k <= SER_STEPS; k++) begin : g_step
    a2r_taylor_step #(
      .SDIV (sine_div(k)),
      .CDIV (cos_div(k)),
      .SUB  ((k % 2) == 1)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (sv[k-1]),
      .in_ser    (ss[k-1]),
      .out_valid (sv[k]),
      .out_ser   (ss[k])
    );
  end

  // fold octant and quadrant back
  q_t  s_oct, c_oct;
  sc_t sc_next;

  always_comb begin
    s_oct = ss[SER_STEPS].swap ? ss[SER_STEPS].ca : ss[SER_STEPS].sa;
    c_oct = ss[SER_STEPS].swap ? ss[SER_STEPS].sa : ss[SER_STEPS].ca;
    unique case (ss[SER_STEPS].quad)
      2'd0: begin sc_next.s = s_oct;  sc_next.c = c_oct;  end
      2'd1: begin sc_next.s = c_oct;  sc_next.c = -s_oct; end
      2'd2: begin sc_next.s = -s_oct; sc_next.c = -c_oct; end
      default: begin sc_next.s = -c_oct; sc_next.c = s_oct; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sv[SER_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_sc <= sc_next;
    end
  end

endmodule

/* hw/rtl/a2r_matrix.sv */
// Matrix build from sines and cosines: axis, Rodrigues matrix, product Rz*Rx*R, output format.
// Five register stages; each of the first four holds one multiplier level. Depends on a2r_pkg.
module a2r_matrix (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  a2r_pkg::sc_t           th,
  input  a2r_pkg::sc_t           ph,
  input  a2r_pkg::sc_t           bt,
  output logic                   out_valid,
  output a2r_pkg::elem_t [8:0]   elems
);
  import a2r_pkg::*;

  logic v1, v2, v3, v4;
  // stage 1: axis and first factor
  q_t a1 [3];
  q_t f1 [9];
  q_t sb1, cb1, omc1;
  // stage 2: outer product and sin(beta) * axis
  q_t aa2 [9];
  q_t sk2 [3];
  q_t f2 [9];
  q_t cb2, omc2;
  // stage 3: Rodrigues matrix
  q_t r3 [9];
  q_t f3 [9];
  q_t kt [9];
  // stage 4: partial products of the matrix product
  q_t pr4 [27];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  always_comb begin
    kt[0] = '0;      kt[1] = -sk2[2]; kt[2] = sk2[1];
    kt[3] = sk2[2];  kt[4] = '0;      kt[5] = -sk2[0];
    kt[6] = -sk2[1]; kt[7] = sk2[0];  kt[8] = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1[0] <= th.c;
      a1[1] <= qmul(th.s, ph.c);
      a1[2] <= qmul(th.s, ph.s);
      f1[0] <= th.c;
      f1[1] <= -qmul(th.s, ph.c);
      f1[2] <= qmul(th.s, ph.s);
      f1[3] <= th.s;
      f1[4] <= qmul(th.c, ph.c);
      f1[5] <= -qmul(th.c, ph.s);
      f1[6] <= '0;
      f1[7] <= ph.s;
      f1[8] <= ph.c;
      sb1   <= bt.s;
      cb1   <= bt.c;
      omc1  <= Q_ONE - bt.c;

      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          aa2[i*3+j] <= qmul(a1[i], a1[j]);
        end
        sk2[i] <= qmul(sb1, a1[i]);
      end
      f2   <= f1;
      cb2  <= cb1;
      omc2 <= omc1;

      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          r3[i*3+j] <= qmul(omc2, aa2[i*3+j]) + ((i == j) ? cb2 : q_t'(0)) + kt[i*3+j];
        end
      end
      f3 <= f2;

      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          for (int k = 0; k < 3; k++) begin
            pr4[(i*3+j)*3+k] <= qmul(f3[i*3+k], r3[k*3+j]);
          end
        end
      end

      for (int e = 0; e < 9; e++) begin
        elems[e] <= to_out(acc_t'(pr4[e*3]) + acc_t'(pr4[e*3+1]) + acc_t'(pr4[e*3+2]));
      end
    end
  end

endmodule

/* hw/rtl/angles_to_rotation_matrix_top.sv */
// Top level of the angle-to-rotation-matrix block: three sine/cosine pipelines, matrix stages
// and a two-entry output buffer. Depends on a2r_pkg, a2r_sincos and a2r_matrix.
//
// Usage:
//   Input channel (s_*): one transaction carries theta, phi and beta, signed angles in units
//   of 1/128 degree. Any 17-bit pattern is legal; angles wrap modulo 360 degrees.
//   Output channel (m_*): one transaction per input, the matrix
//   M = Rz(theta) * Rx(phi) * R(a, beta) with a = (cos t, sin t cos p, sin t sin p),
//   nine signed Q2.14 elements saturated to plus or minus one, row by row.
// Throughput: one transaction per cycle in both directions while the output buffer has room.
// Stages from input acceptance to m_tvalid:
//   4 stages of angle reduction and radian conversion, 18 stages of Taylor series
//   (six steps of three stages), 1 quadrant fold, 5 matrix stages, 1 output buffer write.
// Stall: the whole pipeline advances under one enable that drops only when the two-entry
//   output buffer is full, so one finished result can wait while new input is still taken.
//   Nothing is lost or repeated across stalls.
// Reset (rst, synchronous, active high): clears all valid bits and the output buffer; no
//   other state is kept between transactions.
module angles_to_rotation_matrix_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [55:0]  s_tdata,   // theta_angle[16:0], phi_angle[33:17], beta_angle[50:34], 0
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [143:0] m_tdata    // m00, m01, m02, m10, m11, m12, m20, m21, m22, 16 bits each
);
  import a2r_pkg::*;

  logic        en;
  logic        acc_in;
  logic        th_v, ph_v, bt_v;
  sc_t         th_sc, ph_sc, bt_sc;
  logic        mat_v;
  elem_t [8:0] mat_e;

  // two-entry output buffer; it holds a waiting result while the pipeline keeps moving
  logic [143:0] buf_q [2];
  logic         wr_ptr, rd_ptr;
  logic [1:0]   count;
  logic         push, pop;

  // advance everything while the output buffer has room
  assign en       = (count != 2'd2);
  assign s_tready = en;
  assign acc_in   = s_tvalid & s_tready;

  a2r_sincos u_theta (
    .clk (clk), .rst (rst), .en (en), .in_valid (acc_in),
    .ang (s_tdata[16:0]), .out_valid (th_v), .out_sc (th_sc)
  );

  a2r_sincos u_phi (
    .clk (clk), .rst (rst), .en (en), .in_valid (acc_in),
    .ang (s_tdata[33:17]), .out_valid (ph_v), .out_sc (ph_sc)
  );

  a2r_sincos u_beta (
    .clk (clk), .rst (rst), .en (en), .in_valid (acc_in),
    .ang (s_tdata[50:34]), .out_valid (bt_v), .out_sc (bt_sc)
  );

  a2r_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (th_v),
    .th        (th_sc),
    .ph        (ph_sc),
    .bt        (bt_sc),
    .out_valid (mat_v),
    .elems     (mat_e)
  );

  assign push     = mat_v & en;
  assign pop      = m_tvalid & m_tready;
  assign m_tvalid = (count != 2'd0);
  assign m_tdata  = buf_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_q[wr_ptr] <= mat_e;
    end
  end

  // buffer never overfills
  assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("output buffer overflow");

  // the three angle pipelines stay in lockstep
  assert property (@(posedge clk) disable iff (rst) (th_v == ph_v) && (ph_v == bt_v))
    else $error("sine/cosine pipelines out of step");

  // a push with no pop grows the fill by one
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 2'd1))
    else $error("buffer fill count mismatch");

endmodule

/* sim/angles_to_rotation_matrix_top_tb.sv */
// Testbench for angles_to_rotation_matrix_top: streams angle triples, predicts each rotation
// matrix with an integer Q30 model and checks every element. Depends on a2r_pkg and the RTL.
`timescale 1ns / 1ps

module angles_to_rotation_matrix_top_tb;
  import a2r_pkg::*;

  localparam int NUM_RANDOM = 700;
  localparam int LATENCY    = 29;

  typedef longint mat_t [9];

  // Q30 product, rounded to nearest with halves away from zero
  function automatic longint q30_mul(longint a, longint b);
    longint ma, mb, p;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p = (ma * mb + (longint'(1) << 29)) >>> 30;
    return ((a < 0) != (b < 0)) ? -p : p;
  endfunction

  function automatic longint div_round(longint num, longint den);
    return (num + den / 2) / den;
  endfunction

  // sine and cosine of an angle in 1/128 degree, Q30
  function automatic void angle_trig(input longint ang, output longint s, output longint c);
    longint full, r, q, rem, x, x2, t, sv, cv, tmp;
    bit swap;
    full = 360 * 128;
    r = ang % full;
    if (r < 0) r += full;
    q = r / (90 * 128);
    rem = r - q * 90 * 128;
    swap = 0;
    if (rem > 45 * 128) begin
      rem = 90 * 128 - rem;
      swap = 1;
    end
    x = div_round(rem * 64'sd3373259426, 180 * 128);
    x2 = q30_mul(x, x);
    t = x;
    sv = x;
    for (int k = 1; k <= 5; k++) begin
      t = div_round(q30_mul(t, x2), (2 * k) * (2 * k + 1));
      sv += (k & 1) ? -t : t;
    end
    t = longint'(1) << 30;
    cv = t;
    for (int k = 1; k <= 6; k++) begin
      t = div_round(q30_mul(t, x2), (2 * k - 1) * (2 * k));
      cv += (k & 1) ? -t : t;
    end
    if (swap) begin
      tmp = sv; sv = cv; cv = tmp;
    end
    case (q)
      0: begin s = sv;  c = cv;  end
      1: begin s = cv;  c = -sv; end
      2: begin s = -sv; c = -cv; end
      default: begin s = -cv; c = sv; end
    endcase
  endfunction

  function automatic logic [15:0] q30_to_elem(longint v);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (longint'(1) << 15)) >>> 16;
    if (m > 16384) m = 16384;
    return (v < 0) ? 16'(-m) : 16'(m);
  endfunction

  // M = Rz(theta) * Rx(phi) * R(a, beta), packed m00 in the lowest bits
  function automatic logic [143:0] rotation_of(logic [16:0] th, logic [16:0] ph,
                                               logic [16:0] be);
    longint st, ct, sp, cp, sb, cb, one, acc;
    longint a [3];
    longint kx [3][3];
    longint rr [3][3];
    longint ff [3][3];
    logic [143:0] res;
    one = longint'(1) << 30;
    angle_trig(longint'($signed(th)), st, ct);
    angle_trig(longint'($signed(ph)), sp, cp);
    angle_trig(longint'($signed(be)), sb, cb);
    a[0] = ct;
    a[1] = q30_mul(st, cp);
    a[2] = q30_mul(st, sp);
    kx[0][0] = 0;     kx[0][1] = -a[2]; kx[0][2] = a[1];
    kx[1][0] = a[2];  kx[1][1] = 0;     kx[1][2] = -a[0];
    kx[2][0] = -a[1]; kx[2][1] = a[0];  kx[2][2] = 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        rr[i][j] = q30_mul(one - cb, q30_mul(a[i], a[j])) + (i == j ? cb : 0)
                 + q30_mul(sb, kx[i][j]);
    ff[0][0] = ct; ff[0][1] = -q30_mul(st, cp); ff[0][2] = q30_mul(st, sp);
    ff[1][0] = st; ff[1][1] = q30_mul(ct, cp);  ff[1][2] = -q30_mul(ct, sp);
    ff[2][0] = 0;  ff[2][1] = sp;               ff[2][2] = cp;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += q30_mul(ff[i][k], rr[k][j]);
        res[(i * 3 + j) * 16 +: 16] = q30_to_elem(acc);
      end
    return res;
  endfunction

  // holds predicted matrices in order and compares each delivered one
  class matrix_scoreboard;
    logic [143:0] pending [$];
    int errors;
    int matched;

    function void note_angles(logic [55:0] data);
      pending.push_back(rotation_of(data[16:0], data[33:17], data[50:34]));
    endfunction

    function void check_matrix(logic [143:0] got);
      logic [143:0] want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected matrix %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      for (int e = 0; e < 9; e++)
        if (got[e * 16 +: 16] !== want[e * 16 +: 16]) begin
          $display("%0t: m%0d%0d expected %0d actual %0d", $time, e / 3, e % 3,
                   $signed(want[e * 16 +: 16]), $signed(got[e * 16 +: 16]));
          errors++;
        end
      matched++;
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [55:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [143:0] m_tdata;

  matrix_scoreboard board = new();
  int sent;

  angles_to_rotation_matrix_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // mostly short gaps, now and then a long one, sometimes none for a while
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // present one transaction and hold until accepted; the caller drops valid after the last
  task automatic send_angles(logic [16:0] th, logic [16:0] ph, logic [16:0] be);
    int g;
    g = gap_len();
    repeat (g) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= {5'b0, be, ph, th};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_angles(s_tdata);
    sent++;
    @(negedge clk);
  endtask

  // random angle: in range mostly, at or next to quarter turns, or any 17-bit pattern
  function automatic logic [16:0] pick_angle();
    int r;
    r = $urandom_range(9);
    if (r < 6) return 17'($signed($urandom_range(92160)) - 46080);
    if (r < 8) return 17'(($urandom_range(8) - 4) * 11520 + $urandom_range(2) - 1);
    return 17'($urandom);
  endfunction

  // receiver: random stalls, checking at the accepting edge
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(199) == 0) begin
        m_tready <= 0;
        repeat ($urandom_range(40, 10)) @(negedge clk);
      end
      m_tready <= ($urandom_range(99) < 15) ? 0 : 1;
      @(posedge clk);
      if (m_tvalid && m_tready) board.check_matrix(m_tdata);
      @(negedge clk);
    end
  end

  initial begin
    logic [16:0] ext [8];
    ext = '{17'h00000, 17'd46080, -17'sd46080, 17'h0FFFF, 17'h10000, 17'h1FFFF,
            17'd11520, 17'd5760};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // field extremes, quarter turns, wrapping and eighth-turn boundaries
    for (int i = 0; i < 8; i++) send_angles(ext[i], ext[(i + 3) % 8], ext[(i + 5) % 8]);
    send_angles(17'd5761, 17'd5759, 17'd23040);
    send_angles(17'd34560, -17'sd11520, 17'd46081);
    send_angles(17'h15555, 17'h0AAAA, 17'h1FFFF);
    send_angles(17'h0AAAA, 17'h15555, 17'h00001);
    for (int i = 0; i < NUM_RANDOM; i++) send_angles(pick_angle(), pick_angle(), pick_angle());
    s_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d angle triples, %0d matrices checked, %0d element errors.",
             sent, board.matched, board.errors);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout after %0d triples sent.", sent);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
